// File: src/assert_macros.svh
// Assertion macros used by the checker file of the gamma table block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define PGLP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is never seen at a rising clock edge outside reset.
`define PGLP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/pglp_pkg.sv
// Shared types, constants and helper functions of the gamma table block.
// Depends on nothing; src files but assert_macros.svh and pglp_ram use scoped names; the testbench imports it.
`timescale 1ns / 1ps

package pglp_pkg;

	localparam int DATA_W         = 8;
	localparam int TABLE_ENTRIES  = 256;
	localparam int CHANNEL_TABLES = 4;
	localparam int IDX_W          = $clog2(TABLE_ENTRIES);
	localparam int SEL_W          = $clog2(CHANNEL_TABLES);
	localparam int PROD_W         = 2 * DATA_W;
	localparam int CFG_W          = 2;
	localparam int CFG_IDX_W      = 1;
	localparam int ALPHA_TABLE    = 3;

	typedef enum logic [1:0] {
		FMT_RGBA = 2'd0,
		FMT_RGB  = 2'd1,
		FMT_GRAY = 2'd2,
		FMT_NONE = 2'd3
	} pixel_format_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORMAT  = 1'b0,
		REG_PREMULT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic              rd_en;
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              mul_en;
	} lane_ctrl_t;

	typedef struct packed {
		logic valid;
		logic last;
	} stage_t;

	// Floor of x / 255 for any product of two bytes.
	function automatic logic [DATA_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		t = {1'b0, x} + 17'd1 + {9'd0, x[PROD_W-1:DATA_W]};
		return t[PROD_W-1:DATA_W];
	endfunction

endpackage

// File: src/pglp_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on pglp_pkg for the field widths.
`timescale 1ns / 1ps

interface pglp_in_if;
	logic                                valid;
	logic                                ready;
	logic                                operation;
	logic [pglp_pkg::SEL_W-1:0]          table_select;
	logic [pglp_pkg::IDX_W-1:0]          table_index;
	logic [pglp_pkg::DATA_W-1:0]         table_value;
	logic [pglp_pkg::DATA_W-1:0]         chan_r;
	logic [pglp_pkg::DATA_W-1:0]         chan_g;
	logic [pglp_pkg::DATA_W-1:0]         chan_b;
	logic [pglp_pkg::DATA_W-1:0]         chan_a;
	logic                                last_pixel;

	modport source (
		output valid, operation, table_select, table_index, table_value,
		output chan_r, chan_g, chan_b, chan_a, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, operation, table_select, table_index, table_value,
		input  chan_r, chan_g, chan_b, chan_a, last_pixel,
		output ready
	);
endinterface

interface pglp_out_if;
	logic                        valid;
	logic                        ready;
	logic [pglp_pkg::DATA_W-1:0] out_r;
	logic [pglp_pkg::DATA_W-1:0] out_g;
	logic [pglp_pkg::DATA_W-1:0] out_b;
	logic [pglp_pkg::DATA_W-1:0] out_a;
	logic                        out_last;

	modport source (
		output valid, out_r, out_g, out_b, out_a, out_last,
		input  ready
	);
	modport sink (
		input  valid, out_r, out_g, out_b, out_a, out_last,
		output ready
	);
endinterface

// File: src/pixel_gamma_lut_premultiply_core.sv
// Top level of the per-channel gamma table block with premultiplied alpha.
// Depends on pglp_pkg, pglp_if, pglp_lane and pglp_merge.
//
//   channel   kind          direction  carries
//   feed      valid/ready   in         table loads and pixels
//   result    valid/ready   out        one adjusted pixel per pixel item
//   cfg_*     write port    in         pixel_format, premultiply
//
// One item is taken per clock while feed.ready is high; each pixel is registered at the table
// read, at the product and at the result. Each lane's table has one write and one read port, so
// a load and a pixel share a cycle slot. Loads give no result; no clearing pass follows reset.
// A stall on result backs up one stage at a time, so empty stages still take items.
`timescale 1ns / 1ps

module pixel_gamma_lut_premultiply_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pglp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pglp_pkg::CFG_W-1:0]       cfg_data,
	pglp_in_if.sink                          feed,
	pglp_out_if.source                       result
);

	localparam int NL = pglp_pkg::CHANNEL_TABLES;

	pglp_pkg::pixel_format_t fmt_q;
	logic                    premult_q;
	logic                    premult_on;

	logic en1, en2, en_out;
	logic acc, acc_pixel, acc_load;
	pglp_pkg::stage_t ctrl_s1, ctrl_s2;

	logic [NL-1:0][pglp_pkg::IDX_W-1:0]  raddr;
	logic [NL-1:0][pglp_pkg::DATA_W-1:0] lut_s1;
	logic [NL-1:0][pglp_pkg::PROD_W-1:0] prod_s2;
	pglp_pkg::lane_ctrl_t [NL-1:0]       lane_ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= pglp_pkg::FMT_RGBA;
			premult_q <= 1'b0;
		end else if (cfg_we) begin
			case (pglp_pkg::reg_index_t'(cfg_index))
				pglp_pkg::REG_FORMAT: begin
					fmt_q <= pglp_pkg::pixel_format_t'(cfg_data[1:0]);
				end
				pglp_pkg::REG_PREMULT: begin
					premult_q <= cfg_data[0];
				end
				default: begin
					premult_q <= premult_q;
				end
			endcase
		end
	end

	assign premult_on = premult_q && (fmt_q == pglp_pkg::FMT_RGBA);

	assign en_out     = !result.valid || result.ready;
	assign en2        = !ctrl_s2.valid || en_out;
	assign en1        = !ctrl_s1.valid || en2;
	assign feed.ready = en1;

	assign acc       = feed.valid && en1;
	assign acc_pixel = acc && (feed.operation == pglp_pkg::OP_PIXEL);
	assign acc_load  = acc && (feed.operation == pglp_pkg::OP_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else begin
			if (en1) begin
				ctrl_s1.valid <= acc_pixel;
				ctrl_s1.last  <= feed.last_pixel;
			end
			if (en2) begin
				ctrl_s2 <= ctrl_s1;
			end
		end
	end

	assign raddr = {feed.chan_a, feed.chan_b, feed.chan_g, feed.chan_r};

	for (genvar i = 0; i < NL; i++) begin : g_lane
		logic [pglp_pkg::DATA_W-1:0] scale;

		assign lane_ctrl[i].rd_en  = en1;
		assign lane_ctrl[i].we     = acc_load && (feed.table_select == pglp_pkg::SEL_W'(i));
		assign lane_ctrl[i].waddr  = feed.table_index;
		assign lane_ctrl[i].wdata  = feed.table_value;
		assign lane_ctrl[i].mul_en = en2;

		assign scale = (premult_on && i != pglp_pkg::ALPHA_TABLE)
			? lut_s1[pglp_pkg::ALPHA_TABLE] : pglp_pkg::DATA_W'(1);

		pglp_lane u_lane (
			.clk     (clk),
			.ctrl    (lane_ctrl[i]),
			.raddr   (raddr[i]),
			.scale   (scale),
			.lut_s1  (lut_s1[i]),
			.prod_s2 (prod_s2[i])
		);
	end

	pglp_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_out),
		.ctrl_s2    (ctrl_s2),
		.fmt        (fmt_q),
		.premult_on (premult_on),
		.prod_s2    (prod_s2),
		.valid      (result.valid),
		.last       (result.out_last),
		.r          (result.out_r),
		.g          (result.out_g),
		.b          (result.out_b),
		.a          (result.out_a)
	);

endmodule

// File: src/pglp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pglp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/pglp_lane.sv
// One channel lane: its adjust table and the scaling multiply behind it.
// Depends on pglp_pkg and pglp_ram.
`timescale 1ns / 1ps

module pglp_lane (
	input  logic                          clk,
	input  pglp_pkg::lane_ctrl_t          ctrl,
	input  logic [pglp_pkg::IDX_W-1:0]    raddr,
	input  logic [pglp_pkg::DATA_W-1:0]   scale,
	output logic [pglp_pkg::DATA_W-1:0]   lut_s1,
	output logic [pglp_pkg::PROD_W-1:0]   prod_s2
);

	logic [pglp_pkg::PROD_W-1:0] prod_q;

	pglp_ram #(
		.WIDTH(pglp_pkg::DATA_W),
		.DEPTH(pglp_pkg::TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ctrl.we),
		.waddr (ctrl.waddr),
		.wdata (ctrl.wdata),
		.re    (ctrl.rd_en),
		.raddr (raddr),
		.rdata (lut_s1)
	);

	// The scale is the looked-up alpha when premultiplying a colour lane and one otherwise.
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= pglp_pkg::PROD_W'(lut_s1) * pglp_pkg::PROD_W'(scale);
		end
	end

	assign prod_s2 = prod_q;

endmodule

// File: src/pglp_merge.sv
// Merging stage: scales the lane products and applies the pixel format.
// Depends on pglp_pkg; holds the result register of the block.
`timescale 1ns / 1ps

module pglp_merge (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  logic                                                     en,
	input  pglp_pkg::stage_t                                         ctrl_s2,
	input  pglp_pkg::pixel_format_t                                  fmt,
	input  logic                                                     premult_on,
	input  logic [pglp_pkg::CHANNEL_TABLES-1:0][pglp_pkg::PROD_W-1:0] prod_s2,
	output logic                                                     valid,
	output logic                                                     last,
	output logic [pglp_pkg::DATA_W-1:0]                              r,
	output logic [pglp_pkg::DATA_W-1:0]                              g,
	output logic [pglp_pkg::DATA_W-1:0]                              b,
	output logic [pglp_pkg::DATA_W-1:0]                              a
);

	logic [pglp_pkg::CHANNEL_TABLES-1:0][pglp_pkg::DATA_W-1:0] chan;
	logic [pglp_pkg::DATA_W-1:0] r_d, g_d, b_d, a_d;
	logic                        valid_q, last_q;
	logic [pglp_pkg::DATA_W-1:0] r_q, g_q, b_q, a_q;

	always_comb begin
		for (int i = 0; i < pglp_pkg::CHANNEL_TABLES; i++) begin
			if (premult_on && i != pglp_pkg::ALPHA_TABLE) begin
				chan[i] = pglp_pkg::div255(prod_s2[i]);
			end else begin
				chan[i] = prod_s2[i][pglp_pkg::DATA_W-1:0];
			end
		end
		r_d = '0;
		g_d = '0;
		b_d = '0;
		a_d = '0;
		case (fmt)
			pglp_pkg::FMT_RGBA: begin
				r_d = chan[0];
				g_d = chan[1];
				b_d = chan[2];
				a_d = chan[pglp_pkg::ALPHA_TABLE];
			end
			pglp_pkg::FMT_RGB: begin
				r_d = chan[0];
				g_d = chan[1];
				b_d = chan[2];
			end
			pglp_pkg::FMT_GRAY: begin
				r_d = chan[0];
			end
			default: begin
				r_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctrl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= ctrl_s2.last;
			r_q    <= r_d;
			g_q    <= g_d;
			b_q    <= b_d;
			a_q    <= a_d;
		end
	end

	assign valid = valid_q;
	assign last  = last_q;
	assign r     = r_q;
	assign g     = g_q;
	assign b     = b_q;
	assign a     = a_q;

endmodule

// File: src/pglp_checker.sv
// Port-level checker for the gamma table block, bound to the top level.
// Depends on pglp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pglp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [pglp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pglp_pkg::CFG_W-1:0]     cfg_data,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [pglp_pkg::DATA_W-1:0]    out_r,
	input logic [pglp_pkg::DATA_W-1:0]    out_g,
	input logic [pglp_pkg::DATA_W-1:0]    out_b,
	input logic [pglp_pkg::DATA_W-1:0]    out_a,
	input logic                           out_last
);

	logic [1:0] fmt_q;
	logic       pm_q;
	logic [4*pglp_pkg::DATA_W:0] payload;
	logic       stalled;
	logic       no_alpha;
	logic       gray;
	logic       premul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 2'd0;
			pm_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == pglp_pkg::REG_FORMAT) begin
				fmt_q <= cfg_data[1:0];
			end
			if (cfg_index == pglp_pkg::REG_PREMULT) begin
				pm_q <= cfg_data[0];
			end
		end
	end

	assign payload  = {out_r, out_g, out_b, out_a, out_last};
	assign stalled  = res_valid && !res_ready;
	assign no_alpha = res_valid && (fmt_q != pglp_pkg::FMT_RGBA);
	assign gray     = res_valid && (fmt_q == pglp_pkg::FMT_GRAY);
	assign premul   = res_valid && pm_q && (fmt_q == pglp_pkg::FMT_RGBA);

	`PGLP_ASSERT(a_valid_held, clk, arst_n, stalled |=> res_valid, "result dropped while stalled")
	`PGLP_ASSERT(a_payload_held, clk, arst_n, stalled |=> $stable(payload), "result changed while stalled")
	`PGLP_ASSERT_NEVER(a_alpha_zero, clk, arst_n, no_alpha && out_a != 8'd0, "alpha set outside RGBA")
	`PGLP_ASSERT_NEVER(a_gray_zero, clk, arst_n, gray && (out_g != 8'd0 || out_b != 8'd0), "single channel result has colour")
	`PGLP_ASSERT(a_premul_bound, clk, arst_n, premul |-> (out_r <= out_a && out_g <= out_a && out_b <= out_a), "premultiplied colour above alpha")

endmodule

bind pixel_gamma_lut_premultiply_core pglp_checker u_pglp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.out_r     (result.out_r),
	.out_g     (result.out_g),
	.out_b     (result.out_b),
	.out_a     (result.out_a),
	.out_last  (result.out_last)
);

// File: tb/sv/pixel_gamma_lut_premultiply_core_tb.sv
// Testbench for pixel_gamma_lut_premultiply_core: table loads and pixels with random idling.
// Depends on pglp_pkg and the pglp_in_if and pglp_out_if channel interfaces.
// Expected pixels come from a table-based predictor of the block, or from fixed values in the directed plan.
`timescale 1ns / 1ps

module pixel_gamma_lut_premultiply_core_tb;
	import pglp_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int FULL_SCALE     = 255;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int PLAN_ROWS      = 26;
	localparam int MODE_PHASES    = 8;
	localparam int PHASE_ITEMS    = 75;

	typedef struct packed {
		op_t               op;
		logic [SEL_W-1:0]  sel;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] val;
		logic [DATA_W-1:0] r;
		logic [DATA_W-1:0] g;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] a;
		logic              last;
	} feed_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] r;
		logic [DATA_W-1:0] g;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] a;
		logic              last;
	} pixel_out_t;

	typedef struct {
		pixel_format_t fmt;
		bit            pm;
		feed_item_t    item;
		bit            typed;
		pixel_out_t    want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	pglp_in_if  feed_ch ();
	pglp_out_if result_ch ();

	logic [DATA_W-1:0] gamma_lut [CHANNEL_TABLES][TABLE_ENTRIES];
	bit                entry_set [CHANNEL_TABLES][TABLE_ENTRIES];
	int                loaded_list [CHANNEL_TABLES][$];
	pixel_out_t        pixels_due [$];
	pixel_format_t     cur_fmt;
	bit                cur_pm;
	bit                typed_pend;
	pixel_out_t        typed_want;
	bit                calm;
	int                errors;
	int                idle_cycles;
	int                rx_gap;
	int                rx_hold;
	feed_item_t        seen;
	pixel_out_t        due;
	plan_row_t         plan [PLAN_ROWS];

	pixel_format_t phase_fmt [MODE_PHASES] = '{FMT_RGBA, FMT_RGB, FMT_GRAY, FMT_RGBA,
		FMT_NONE, FMT_RGB, FMT_GRAY, FMT_RGBA};
	bit            phase_pm [MODE_PHASES]  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

	pixel_gamma_lut_premultiply_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.feed      (feed_ch),
		.result    (result_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic feed_item_t load_of(input logic [SEL_W-1:0] sel,
		input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		feed_item_t it;
		it = '{OP_LOAD, sel, idx, val, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1};
		return it;
	endfunction

	function automatic feed_item_t pixel_of(input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] g,
		input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] a, input logic last);
		feed_item_t it;
		it = '{OP_PIXEL, 2'd3, 8'hFF, 8'hFF, r, g, b, a, last};
		return it;
	endfunction

	function automatic pixel_out_t result_of(input logic [DATA_W-1:0] r, input logic [DATA_W-1:0] g,
		input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] a, input logic last);
		pixel_out_t o;
		o = '{r, g, b, a, last};
		return o;
	endfunction

	function automatic logic [DATA_W-1:0] alpha_scale(input logic [DATA_W-1:0] c,
		input logic [DATA_W-1:0] a);
		int p;
		p = int'(c) * int'(a) / FULL_SCALE;
		return p[DATA_W-1:0];
	endfunction

	function automatic pixel_out_t remap_pixel(input feed_item_t px);
		pixel_out_t o;
		o = '0;
		o.last = px.last;
		case (cur_fmt)
			FMT_RGBA, FMT_RGB: begin
				o.r = gamma_lut[0][px.r];
				o.g = gamma_lut[1][px.g];
				o.b = gamma_lut[2][px.b];
				if (cur_fmt == FMT_RGBA) begin
					o.a = gamma_lut[ALPHA_TABLE][px.a];
					if (cur_pm) begin
						o.r = alpha_scale(o.r, o.a);
						o.g = alpha_scale(o.g, o.a);
						o.b = alpha_scale(o.b, o.a);
					end
				end
			end
			FMT_GRAY: begin
				o.r = gamma_lut[0][px.r];
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	// Pixels only ever address table entries that have been loaded.
	function automatic logic [DATA_W-1:0] pick_entry(input int t);
		int v;
		v = $urandom_range(0, TABLE_ENTRIES - 1);
		if (!entry_set[t][v])
			v = loaded_list[t][$urandom_range(0, loaded_list[t].size() - 1)];
		return v[DATA_W-1:0];
	endfunction

	function automatic feed_item_t random_item();
		feed_item_t it;
		it.sel  = SEL_W'($urandom_range(0, CHANNEL_TABLES - 1));
		it.idx  = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
		it.val  = DATA_W'($urandom_range(0, 255));
		it.last = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 3) begin
			it.op = OP_LOAD;
			it.r  = DATA_W'($urandom_range(0, 255));
			it.g  = DATA_W'($urandom_range(0, 255));
			it.b  = DATA_W'($urandom_range(0, 255));
			it.a  = DATA_W'($urandom_range(0, 255));
		end else begin
			it.op = OP_PIXEL;
			it.r  = pick_entry(0);
			it.g  = pick_entry(1);
			it.b  = pick_entry(2);
			it.a  = pick_entry(ALPHA_TABLE);
		end
		return it;
	endfunction

	function automatic void check_byte(input string name, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	task automatic push_item(input feed_item_t it, input bit typed, input pixel_out_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			feed_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (it.op == OP_LOAD && !entry_set[it.sel][it.idx]) begin
			entry_set[it.sel][it.idx] = 1'b1;
			loaded_list[it.sel].push_back(int'(it.idx));
		end
		feed_ch.valid        <= 1'b1;
		feed_ch.operation    <= it.op;
		feed_ch.table_select <= it.sel;
		feed_ch.table_index  <= it.idx;
		feed_ch.table_value  <= it.val;
		feed_ch.chan_r       <= it.r;
		feed_ch.chan_g       <= it.g;
		feed_ch.chan_b       <= it.b;
		feed_ch.chan_a       <= it.a;
		feed_ch.last_pixel   <= it.last;
		typed_pend           <= typed;
		typed_want           <= want;
		@(posedge clk);
		while (!feed_ch.ready) @(posedge clk);
	endtask

	// Loads give no result, so the task waits for due pixels to drain and lets the block settle before a write.
	task automatic apply_mode(input pixel_format_t fmt, input bit pm);
		feed_ch.valid <= 1'b0;
		@(posedge clk);
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_FORMAT;
		cfg_data  <= fmt;
		@(posedge clk);
		cfg_index <= REG_PREMULT;
		cfg_data  <= {1'b0, pm};
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_fmt = fmt;
		cur_pm  = pm;
	endtask

	always @(posedge clk) begin
		if (arst_n && feed_ch.valid && feed_ch.ready) begin
			seen.op   = op_t'(feed_ch.operation);
			seen.sel  = feed_ch.table_select;
			seen.idx  = feed_ch.table_index;
			seen.val  = feed_ch.table_value;
			seen.r    = feed_ch.chan_r;
			seen.g    = feed_ch.chan_g;
			seen.b    = feed_ch.chan_b;
			seen.a    = feed_ch.chan_a;
			seen.last = feed_ch.last_pixel;
			if (seen.op == OP_LOAD)
				gamma_lut[seen.sel][seen.idx] = seen.val;
			else
				pixels_due.push_back(typed_pend ? typed_want : remap_pixel(seen));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (pixels_due.size() == 0) begin
					$error("result item with no pixel waiting");
					errors++;
				end else begin
					due = pixels_due.pop_front();
					check_byte("out_r", due.r, result_ch.out_r);
					check_byte("out_g", due.g, result_ch.out_g);
					check_byte("out_b", due.b, result_ch.out_b);
					check_byte("out_a", due.a, result_ch.out_a);
					check_byte("out_last", {7'd0, due.last}, {7'd0, result_ch.out_last});
				end
				rx_gap = calm ? 0 : $urandom_range(0, 6);
				if (rx_gap != 0) begin
					result_ch.ready <= 1'b0;
					rx_hold         <= rx_gap;
				end
			end else if (!result_ch.ready) begin
				if (rx_hold <= 1)
					result_ch.ready <= 1'b1;
				rx_hold <= rx_hold - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((feed_ch.valid && feed_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_FORMAT;
		cfg_data             = '0;
		feed_ch.valid        = 1'b0;
		feed_ch.operation    = OP_LOAD;
		feed_ch.table_select = '0;
		feed_ch.table_index  = '0;
		feed_ch.table_value  = '0;
		feed_ch.chan_r       = '0;
		feed_ch.chan_g       = '0;
		feed_ch.chan_b       = '0;
		feed_ch.chan_a       = '0;
		feed_ch.last_pixel   = 1'b0;
		result_ch.ready      = 1'b0;
		cur_fmt              = FMT_RGBA;
		cur_pm               = 1'b0;
		typed_pend           = 1'b0;
		typed_want           = '0;
		calm                 = 1'b0;
		errors               = 0;
		idle_cycles          = 0;
		rx_hold              = 0;

		plan = '{
			'{FMT_RGBA, 1'b0, load_of(0, 8'h00, 8'h00), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(0, 8'hFF, 8'hFF), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(0, 8'hAA, 8'h55), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(1, 8'h00, 8'hFF), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(1, 8'hFF, 8'h00), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(1, 8'h55, 8'hAA), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(2, 8'h00, 8'h00), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(2, 8'hFF, 8'hFF), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(2, 8'hAA, 8'h55), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(3, 8'h00, 8'h00), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(3, 8'hFF, 8'hFF), 1'b0, '0},
			'{FMT_RGBA, 1'b0, load_of(3, 8'h80, 8'h80), 1'b0, '0},
			'{FMT_RGBA, 1'b0, pixel_of(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1),
				1'b1, result_of(255, 255, 255, 255, 1'b1)},
			'{FMT_RGBA, 1'b0, pixel_of(8'h00, 8'hFF, 8'h00, 8'h00, 1'b0),
				1'b1, result_of(0, 0, 0, 0, 1'b0)},
			'{FMT_RGBA, 1'b1, pixel_of(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b0),
				1'b1, result_of(255, 255, 255, 255, 1'b0)},
			'{FMT_RGBA, 1'b1, pixel_of(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1),
				1'b1, result_of(0, 0, 0, 0, 1'b1)},
			'{FMT_RGBA, 1'b1, pixel_of(8'hFF, 8'h00, 8'hFF, 8'h80, 1'b1),
				1'b1, result_of(128, 128, 128, 128, 1'b1)},
			'{FMT_RGBA, 1'b1, pixel_of(8'hAA, 8'h55, 8'hAA, 8'h80, 1'b0), 1'b0, '0},
			'{FMT_RGB, 1'b1, pixel_of(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1),
				1'b1, result_of(255, 255, 255, 0, 1'b1)},
			'{FMT_RGB, 1'b0, pixel_of(8'hAA, 8'h55, 8'hAA, 8'h80, 1'b0), 1'b0, '0},
			'{FMT_GRAY, 1'b1, pixel_of(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1),
				1'b1, result_of(255, 0, 0, 0, 1'b1)},
			'{FMT_GRAY, 1'b0, pixel_of(8'hAA, 8'h55, 8'hAA, 8'h80, 1'b0), 1'b0, '0},
			'{FMT_NONE, 1'b1, pixel_of(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1),
				1'b1, result_of(0, 0, 0, 0, 1'b1)},
			'{FMT_NONE, 1'b0, pixel_of(8'h00, 8'hFF, 8'h00, 8'h00, 1'b0),
				1'b1, result_of(0, 0, 0, 0, 1'b0)},
			'{FMT_RGBA, 1'b1, load_of(0, 8'h80, 8'h3C), 1'b0, '0},
			'{FMT_RGBA, 1'b1, pixel_of(8'h80, 8'h55, 8'hAA, 8'hFF, 1'b1), 1'b0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].fmt != cur_fmt || plan[i].pm != cur_pm)
				apply_mode(plan[i].fmt, plan[i].pm);
			push_item(plan[i].item, plan[i].typed, plan[i].want);
		end

		for (int p = 0; p < MODE_PHASES; p++) begin
			apply_mode(phase_fmt[p], phase_pm[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 25 == 0)
					calm <= ($urandom_range(0, 3) == 0);
				push_item(random_item(), 1'b0, '0);
			end
		end

		feed_ch.valid <= 1'b0;
		@(posedge clk);
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
